### rtl/u16u8_pkg.sv
// Types and constants shared by the UTF-16 to UTF-8 transcoder modules.
package u16u8_pkg;

  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [15:0] HIGH_SURR_MIN  = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX  = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN   = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX   = 16'hDFFF;
  localparam logic [20:0] SUPP_OFFSET    = 21'h10000;
  localparam logic [7:0]  LEAD_TWO       = 8'hC0;
  localparam logic [7:0]  LEAD_THREE     = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR      = 8'hF0;
  localparam logic [7:0]  CONT_MARK      = 8'h80;
  localparam logic [7:0]  CONT_MASK      = 8'h3F;
  localparam int unsigned MAX_BYTES      = 4;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       is_error;
    logic       run_last;
    logic       string_end;
  } out_word_t;

  // All the bytes that one code unit produces, handed from encoder to serializer.
  typedef struct packed {
    logic [2:0]                    cnt;
    logic [MAX_BYTES-1:0][7:0]     bytes;
    logic                          err;
    logic                          last;
  } grp_t;

endpackage

### rtl/u16u8_encode.sv
// Input register, surrogate tracking and byte-group encoding of one code unit.
module u16u8_encode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  u16u8_pkg::in_word_t in_data,
  output logic                grp_vld,
  input  logic                grp_ready,
  output u16u8_pkg::grp_t     grp
);
  import u16u8_pkg::*;

  logic        vld_r;
  in_word_t    word_r;
  logic        hp_r, hp_nxt;
  logic        fail_r, fail_nxt;
  logic [9:0]  held_r, held_nxt;
  logic        move;
  logic        is_high, is_low;
  logic [15:0] ch;
  logic [20:0] cp;

  assign ch      = word_r.code_unit;
  assign is_high = (ch >= HIGH_SURR_MIN) && (ch <= HIGH_SURR_MAX);
  assign is_low  = (ch >= LOW_SURR_MIN) && (ch <= LOW_SURR_MAX);
  assign cp      = {1'b0, held_r, ch[9:0]} + SUPP_OFFSET;

  always_comb begin
    grp      = '0;
    grp.last = word_r.string_last;
    hp_nxt   = hp_r;
    fail_nxt = fail_r;
    held_nxt = held_r;
    if (fail_r) begin
      if (word_r.string_last) begin
        grp.cnt  = 3'd1;
        grp.err  = 1'b1;
        fail_nxt = 1'b0;
        hp_nxt   = 1'b0;
        held_nxt = '0;
      end
    end else if (hp_r) begin
      hp_nxt   = 1'b0;
      held_nxt = '0;
      if (!is_low) begin
        if (word_r.string_last) begin
          grp.cnt = 3'd1;
          grp.err = 1'b1;
        end else begin
          fail_nxt = 1'b1;
        end
      end else begin
        grp.cnt      = 3'd4;
        grp.bytes[0] = LEAD_FOUR | {5'b0, cp[20:18]};
        grp.bytes[1] = CONT_MARK | ({2'b0, cp[17:12]} & CONT_MASK);
        grp.bytes[2] = CONT_MARK | ({2'b0, cp[11:6]} & CONT_MASK);
        grp.bytes[3] = CONT_MARK | ({2'b0, cp[5:0]} & CONT_MASK);
      end
    end else if (is_high) begin
      if (word_r.string_last) begin
        grp.cnt = 3'd1;
        grp.err = 1'b1;
      end else begin
        hp_nxt   = 1'b1;
        held_nxt = ch[9:0];
      end
    end else if (ch < ONE_BYTE_LIMIT) begin
      grp.cnt      = 3'd1;
      grp.bytes[0] = ch[7:0];
    end else if (ch < TWO_BYTE_LIMIT) begin
      grp.cnt      = 3'd2;
      grp.bytes[0] = LEAD_TWO | {3'b0, ch[10:6]};
      grp.bytes[1] = CONT_MARK | {2'b0, ch[5:0]};
    end else begin
      grp.cnt      = 3'd3;
      grp.bytes[0] = LEAD_THREE | {4'b0, ch[15:12]};
      grp.bytes[1] = CONT_MARK | {2'b0, ch[11:6]};
      grp.bytes[2] = CONT_MARK | {2'b0, ch[5:0]};
    end
  end

  // A word that yields no bytes leaves without waiting on the serializer.
  assign move     = vld_r && ((grp.cnt == 3'd0) || grp_ready);
  assign in_stall = vld_r && !move;
  assign grp_vld  = vld_r && (grp.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      hp_r   <= 1'b0;
      fail_r <= 1'b0;
      held_r <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        vld_r <= 1'b1;
      end else if (move) begin
        vld_r <= 1'b0;
      end
      if (move) begin
        hp_r   <= hp_nxt;
        fail_r <= fail_nxt;
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r <= in_data;
    end
  end

endmodule

### rtl/u16u8_serial.sv
// Result register that hands out a byte group one word per cycle while out_stall is low.
module u16u8_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 grp_vld,
  output logic                 grp_ready,
  input  u16u8_pkg::grp_t      grp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u16u8_pkg::out_word_t out_data
);
  import u16u8_pkg::*;

  logic       busy_r;
  grp_t       grp_r;
  logic [1:0] idx_r;
  logic       at_last;
  logic       leave_last;

  assign at_last    = (({1'b0, idx_r} + 3'd1) == grp_r.cnt);
  assign leave_last = busy_r && !out_stall && at_last;
  assign grp_ready  = !busy_r || leave_last;

  assign out_valid           = busy_r;
  assign out_data.utf8_byte  = grp_r.bytes[idx_r];
  assign out_data.is_error   = grp_r.err;
  assign out_data.run_last   = at_last;
  assign out_data.string_end = at_last && grp_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (grp_vld && grp_ready) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (leave_last) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else if (busy_r && !out_stall) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_vld && grp_ready) begin
      grp_r <= grp;
    end
  end

endmodule

### rtl/utf16_to_utf8_transcoder_top.sv
// A word is registered in the encoder and its byte group in the serializer.
// Throughput: one output byte per cycle while out_stall is low; a word yields
// 1 to 4 bytes, or none for a held high surrogate or a word dropped from a failed string.
// The serializer's single byte port sets the rate; the next word is encoded
// while the current group drains. Reset (rst_n low, synchronous) empties both
// stages and clears any held high surrogate and string failure.
module utf16_to_utf8_transcoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  u16u8_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u16u8_pkg::out_word_t out_data
);
  import u16u8_pkg::*;

  grp_t grp;
  logic grp_vld;
  logic grp_ready;

  u16u8_encode u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .grp_vld  (grp_vld),
    .grp_ready(grp_ready),
    .grp      (grp)
  );

  u16u8_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .grp_vld  (grp_vld),
    .grp_ready(grp_ready),
    .grp      (grp),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

### rtl/u16u8_checker.sv
// Port-level checks for the transcoder, bound to the top level.
module u16u8_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input u16u8_pkg::in_word_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input u16u8_pkg::out_word_t out_data
);
  import u16u8_pkg::*;

  // A stalled input word must be held by the sender.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input word changed");

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // An error word is a lone zero byte that closes its string.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_error |->
      out_data.utf8_byte == 8'h00 && out_data.run_last && out_data.string_end)
    else $error("malformed error word");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_end |-> out_data.run_last)
    else $error("string end without run end");

  // Following words of one group are continuation bytes.
  a_cont_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && !out_stall && !out_data.run_last) && out_valid |->
      out_data.utf8_byte[7:6] == 2'b10)
    else $error("expected continuation byte");

endmodule

bind utf16_to_utf8_transcoder_top u16u8_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

### test/testbench.sv
// Self-checking testbench for the UTF-16 to UTF-8 transcoder, with a built-in byte predictor.
module testbench;
  import u16u8_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef enum {U_ASCII, U_TWO, U_THREE, U_HIGH, U_LOW, U_ANY} unit_class_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  utf16_to_utf8_transcoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Predictor state: a held high surrogate and the failed-string flag.
  logic [9:0] held_bits   = '0;
  logic       high_held   = 1'b0;
  logic       str_failed  = 1'b0;

  out_word_t bytes_due[$];
  int        words_sent   = 0;
  int        strings_sent = 0;
  int        bytes_seen   = 0;
  int        error_words  = 0;
  int        mismatches   = 0;
  int        cycles       = 0;
  bit        idle_on      = 1'b1;
  bit        stall_on     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes still due", $time, bytes_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Works out the bytes that one accepted word must produce and queues them.
  function automatic void encode_unit(input in_word_t w);
    logic [15:0] cu;
    logic [20:0] cp;
    logic [7:0]  b [4];
    logic        err;
    int          n;
    out_word_t   r;
    cu  = w.code_unit;
    err = 1'b0;
    n   = 0;
    if (str_failed) begin
      err = w.string_last;
    end else if (high_held) begin
      high_held = 1'b0;
      if (cu < LOW_SURR_MIN || cu > LOW_SURR_MAX) begin
        held_bits = '0;
        if (w.string_last) err = 1'b1;
        else str_failed = 1'b1;
      end else begin
        cp = {1'b0, held_bits, 10'b0} + 21'(cu - LOW_SURR_MIN) + SUPP_OFFSET;
        b[0] = LEAD_FOUR | {5'b0, cp[20:18]};
        b[1] = CONT_MARK | {2'b0, cp[17:12]};
        b[2] = CONT_MARK | {2'b0, cp[11:6]};
        b[3] = CONT_MARK | {2'b0, cp[5:0]};
        n = 4;
        held_bits = '0;
      end
    end else if (cu >= HIGH_SURR_MIN && cu <= HIGH_SURR_MAX) begin
      if (w.string_last) begin
        err = 1'b1;
      end else begin
        held_bits = cu[9:0];
        high_held = 1'b1;
      end
    end else if (cu < ONE_BYTE_LIMIT) begin
      b[0] = cu[7:0];
      n = 1;
    end else if (cu < TWO_BYTE_LIMIT) begin
      b[0] = LEAD_TWO | {3'b0, cu[10:6]};
      b[1] = CONT_MARK | {2'b0, cu[5:0]};
      n = 2;
    end else begin
      b[0] = LEAD_THREE | {4'b0, cu[15:12]};
      b[1] = CONT_MARK | {2'b0, cu[11:6]};
      b[2] = CONT_MARK | {2'b0, cu[5:0]};
      n = 3;
    end
    // An aborted string reports once, on its last word, and all state clears.
    if (err) begin
      str_failed = 1'b0;
      high_held  = 1'b0;
      held_bits  = '0;
      b[0]       = 8'h00;
      n          = 1;
    end
    for (int k = 0; k < n; k++) begin
      r.utf8_byte  = b[k];
      r.is_error   = err;
      r.run_last   = (k == n - 1);
      r.string_end = (k == n - 1) && w.string_last;
      bytes_due = {bytes_due, r};
    end
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 24);
  endfunction

  function automatic logic [15:0] rand_unit(input unit_class_t c);
    case (c)
      U_ASCII: return 16'($urandom_range(0, ONE_BYTE_LIMIT - 1));
      U_TWO:   return 16'($urandom_range(ONE_BYTE_LIMIT, TWO_BYTE_LIMIT - 1));
      U_THREE: begin
        if ($urandom_range(0, 3) == 0)
          return 16'($urandom_range(LOW_SURR_MAX + 1, 16'hFFFF));
        return 16'($urandom_range(TWO_BYTE_LIMIT, HIGH_SURR_MIN - 1));
      end
      U_HIGH:  return 16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX));
      U_LOW:   return 16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX));
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one word and predicts its bytes once the block takes it.
  task automatic send_word(input logic [15:0] cu, input logic last);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) >= 55) ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{code_unit: cu, string_last: last};
    do @(posedge clk); while (in_stall);
    encode_unit('{code_unit: cu, string_last: last});
    words_sent++;
    if (last) strings_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // A well-formed string: BMP characters and proper surrogate pairs.
  task automatic send_text(input int len);
    logic [15:0] units[$];
    int          r;
    while (units.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 25) units = {units, rand_unit(U_ASCII)};
      else if (r < 45) units = {units, rand_unit(U_TWO)};
      else if (r < 80) units = {units, rand_unit(U_THREE)};
      else units = {units, rand_unit(U_HIGH), rand_unit(U_LOW)};
    end
    foreach (units[i]) send_word(units[i], i == units.size() - 1);
  endtask

  // A string heavy in surrogates, most of them badly paired.
  task automatic send_broken(input int len);
    int          r;
    unit_class_t c;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) c = U_HIGH;
      else if (r < 55) c = U_LOW;
      else c = U_ANY;
      send_word(rand_unit(c), i == len - 1);
    end
  endtask

  task automatic test_directed();
    // Range edges of the one-, two- and three-byte encodings in one string.
    send_word(16'h0000, 1'b0);
    send_word(16'h007F, 1'b0);
    send_word(16'h0080, 1'b0);
    send_word(16'h07FF, 1'b0);
    send_word(16'h0800, 1'b0);
    send_word(16'hD7FF, 1'b0);
    send_word(16'hE000, 1'b0);
    send_word(16'hFFFF, 1'b1);
    // Lowest and highest supplementary code points, then lone low surrogates.
    send_word(16'hD800, 1'b0);
    send_word(16'hDC00, 1'b1);
    send_word(16'hDBFF, 1'b0);
    send_word(16'hDFFF, 1'b0);
    send_word(16'hDC00, 1'b0);
    send_word(16'hDFFF, 1'b1);
    // High surrogate as the last word of a string.
    send_word(16'hDBFF, 1'b1);
    // Held high surrogate followed by a plain last word.
    send_word(16'hD800, 1'b0);
    send_word(16'h0041, 1'b1);
    // Failure in mid-string; later words are dropped until the last one.
    send_word(16'hD800, 1'b0);
    send_word(16'h0041, 1'b0);
    send_word(16'hDC00, 1'b0);
    send_word(16'hDBFF, 1'b1);
    // High followed by another high.
    send_word(16'hD801, 1'b0);
    send_word(16'hD802, 1'b0);
    send_word(16'h0062, 1'b1);
    release_input();
    wait_drain();
  endtask

  task automatic test_text();
    int stop_at;
    stop_at = words_sent + 280;
    while (words_sent < stop_at) begin
      idle_on  = ($urandom_range(0, 4) != 0);
      stall_on = ($urandom_range(0, 4) != 0);
      send_text($urandom_range(1, 8));
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_full_rate();
    int stop_at;
    idle_on  = 1'b0;
    stall_on = 1'b0;
    stop_at  = words_sent + 50;
    while (words_sent < stop_at) send_text($urandom_range(2, 10));
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_drain_pauses();
    for (int i = 0; i < 4; i++) begin
      send_text($urandom_range(1, 3));
      release_input();
      wait_drain();
      // The held high surrogate must survive an idle input.
      send_word(rand_unit(U_HIGH), 1'b0);
      release_input();
      wait_drain();
      send_word(rand_unit(U_LOW), 1'b1);
    end
    release_input();
    wait_drain();
  endtask

  task automatic test_broken();
    int stop_at;
    stop_at = words_sent + 110;
    while (words_sent < stop_at) send_broken($urandom_range(1, 6));
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_text();
    test_full_rate();
    test_drain_pauses();
    test_broken();
    release_input();
    wait_drain();
    $display("Sent %0d words in %0d strings; checked %0d bytes, %0d of them error words.",
             words_sent, strings_sent, bytes_seen, error_words);
    $display("Covered all encoding lengths, surrogate pairs, pairing faults and idle gaps.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      n = stall_on ? pick_gap() : 0;
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_bytes
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (out_data.is_error === 1'b1) error_words++;
      if (bytes_due.size() == 0) begin
        mismatches++;
        $display("%0t: byte with nothing due: expected none, got %h", $time, out_data);
      end else begin
        want = bytes_due.pop_front();
        if (out_data.utf8_byte !== want.utf8_byte || out_data.is_error !== want.is_error ||
            out_data.run_last !== want.run_last || out_data.string_end !== want.string_end) begin
          mismatches++;
          $display("%0t: expected byte %h err %b run_last %b end %b, got %h %b %b %b",
                   $time, want.utf8_byte, want.is_error, want.run_last, want.string_end,
                   out_data.utf8_byte, out_data.is_error, out_data.run_last,
                   out_data.string_end);
        end
      end
    end
  end

endmodule
